>>> design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types and constants for the temperature and pressure compensation
// pipeline and its pipelined divider.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TEMP_TRIM  = 2'd0,
		REG_PRESS_A    = 2'd1,
		REG_PRESS_B    = 2'd2,
		REG_PRESS_C    = 2'd3
	} cfg_reg_t;

	// Divider geometry: 64-bit dividend magnitude, 31-bit divisor magnitude.
	localparam int DIV_NW     = 64;
	localparam int DIV_DW     = 31;
	localparam int DIV_STAGES = DIV_NW;

	// Output limits.
	localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
	localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
	localparam logic [24:0]        PRESS_MAX = 25'h1FF_FFFF;

	// Fine temperature offset used by the pressure formula.
	localparam logic signed [25:0] T_FINE_OFS = 26'sd128000;

	// Side information that travels with each divide request.
	typedef struct packed {
		logic               neg;
		logic               dz;
		logic signed [14:0] tc;
	} div_tag_t;

endpackage

>>> design/bsc_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, one request per cycle.
// ----------------------------------------------------------------------------
module bsc_div
	import bsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DIV_NW-1:0] in_num,
	input  logic [DIV_DW-1:0] in_den,
	input  div_tag_t          in_tag,
	output logic              out_valid,
	output logic [DIV_NW-1:0] out_quo,
	output div_tag_t          out_tag
);

	logic              div_vld_s  [DIV_STAGES];
	logic [DIV_DW-1:0] div_rem_s  [DIV_STAGES];
	logic [DIV_NW-1:0] div_work_s [DIV_STAGES];
	logic [DIV_DW-1:0] div_den_s  [DIV_STAGES];
	div_tag_t          div_tag_s  [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic              vld_prev;
		logic [DIV_DW-1:0] rem_prev;
		logic [DIV_NW-1:0] work_prev;
		logic [DIV_DW-1:0] den_prev;
		div_tag_t          tag_prev;
		logic [DIV_DW:0]   trial;
		logic [DIV_DW:0]   diff;
		logic              qbit;

		// The first stage starts from a zero remainder and the full dividend.
		if (i == 0) begin : g_first
			assign vld_prev  = in_valid;
			assign rem_prev  = '0;
			assign work_prev = in_num;
			assign den_prev  = in_den;
			assign tag_prev  = in_tag;
		end else begin : g_next
			assign vld_prev  = div_vld_s[i-1];
			assign rem_prev  = div_rem_s[i-1];
			assign work_prev = div_work_s[i-1];
			assign den_prev  = div_den_s[i-1];
			assign tag_prev  = div_tag_s[i-1];
		end

		// Bring down the next dividend bit and try the subtraction.
		always_comb begin
			trial = {rem_prev, work_prev[DIV_NW-1]};
			diff  = trial - {1'b0, den_prev};
			qbit  = (trial >= {1'b0, den_prev});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i] <= 1'b0;
			end else begin
				div_vld_s[i] <= vld_prev;
			end
		end

		// Quotient bits shift in from the bottom as dividend bits leave the top.
		always_ff @(posedge clk) begin
			div_rem_s[i]  <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			div_work_s[i] <= {work_prev[DIV_NW-2:0], qbit};
			div_den_s[i]  <= den_prev;
			div_tag_s[i]  <= tag_prev;
		end
	end

	assign out_valid = div_vld_s[DIV_STAGES-1];
	assign out_quo   = div_work_s[DIV_STAGES-1];
	assign out_tag   = div_tag_s[DIV_STAGES-1];

endmodule

>>> design/baro_sensor_compensation_top.sv
// Each result is strobed on done after the registered stages 1 to 9, the divider
// and stages 74 to 79.
// Throughput: one request per cycle; busy never rises, the receiver cannot stall.
// Most of the latency is the 64-stage divider, one quotient bit per stage.
// Reset clears all valid bits and the trim registers to zero.
// ----------------------------------------------------------------------------
// Barometric sensor compensation top level
// Converts raw temperature and pressure samples into compensated values
// using factory trim words, in a fully pipelined 64-bit datapath.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_top
	import bsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [19:0]        raw_temp,
	input  logic [19:0]        raw_press,
	output logic               done,
	output logic signed [14:0] temp_centi,
	output logic [24:0]        press_q8,
	output logic               divisor_zero,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	// Trim registers and their fields.
	logic [47:0] temp_trim_q;
	logic [63:0] press_trim_a_q;
	logic [63:0] press_trim_b_q;
	logic [15:0] press_trim_c_q;

	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_trim_q[15:0];
	assign t2 = temp_trim_q[31:16];
	assign t3 = temp_trim_q[47:32];
	assign p1 = press_trim_a_q[15:0];
	assign p2 = press_trim_a_q[31:16];
	assign p3 = press_trim_a_q[47:32];
	assign p4 = press_trim_a_q[63:48];
	assign p5 = press_trim_b_q[15:0];
	assign p6 = press_trim_b_q[31:16];
	assign p7 = press_trim_b_q[47:32];
	assign p8 = press_trim_b_q[63:48];
	assign p9 = press_trim_c_q;

	// The pipeline never stalls, so both ports are always open.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q    <= '0;
			press_trim_a_q <= '0;
			press_trim_b_q <= '0;
			press_trim_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEMP_TRIM: temp_trim_q    <= cfg_data[47:0];
				REG_PRESS_A:   press_trim_a_q <= cfg_data;
				REG_PRESS_B:   press_trim_b_q <= cfg_data;
				REG_PRESS_C:   press_trim_c_q <= cfg_data[15:0];
			endcase
		end
	end

	// Valid bits for the stages around the divider.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s74, vld_s75, vld_s76, vld_s77, vld_s78, vld_s79;
	logic div_out_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s74 <= 1'b0;
			vld_s75 <= 1'b0;
			vld_s76 <= 1'b0;
			vld_s77 <= 1'b0;
			vld_s78 <= 1'b0;
			vld_s79 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s74 <= div_out_vld;
			vld_s75 <= vld_s74;
			vld_s76 <= vld_s75;
			vld_s77 <= vld_s76;
			vld_s78 <= vld_s77;
			vld_s79 <= vld_s78;
		end
	end

	// Stage 1: temperature offsets and the first two products.
	logic signed [17:0] at;
	logic signed [16:0] bt;
	logic signed [33:0] m1_s1, bb_s1;
	logic [19:0]        rp_s1;

	always_comb begin
		at = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
		bt = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, t1});
	end

	always_ff @(posedge clk) begin
		m1_s1 <= at * t2;
		bb_s1 <= bt * bt;
		rp_s1 <= raw_press;
	end

	// Stage 2: scale the linear term and multiply the square term by T3.
	logic signed [22:0] v1t_s2;
	logic signed [37:0] m2_s2;
	logic [19:0]        rp_s2;
	logic signed [21:0] bbs;

	assign bbs = bb_s1[33:12];

	always_ff @(posedge clk) begin
		v1t_s2 <= m1_s1[33:11];
		m2_s2  <= bbs * t3;
		rp_s2  <= rp_s1;
	end

	// Stage 3: fine temperature.
	logic signed [24:0] tf_s3;
	logic [19:0]        rp_s3;

	always_ff @(posedge clk) begin
		tf_s3 <= $signed({{2{v1t_s2[22]}}, v1t_s2}) + $signed({m2_s2[37], m2_s2[37:14]});
		rp_s3 <= rp_s2;
	end

	// Stage 4: temperature output and the first pressure products.
	logic signed [25:0] vp;
	logic signed [27:0] tc5;
	logic signed [19:0] tcs;
	logic signed [14:0] tc_c;
	logic signed [51:0] sq_s4;
	logic signed [41:0] mp5_s4, mp2_s4;
	logic signed [14:0] tc_s4;
	logic [19:0]        rp_s4;

	always_comb begin
		vp  = 26'(tf_s3) - T_FINE_OFS;
		tc5 = 28'(tf_s3) * 28'sd5 + 28'sd128;
		tcs = tc5[27:8];
		if (tcs < 20'(TEMP_MIN)) begin
			tc_c = TEMP_MIN;
		end else if (tcs > 20'(TEMP_MAX)) begin
			tc_c = TEMP_MAX;
		end else begin
			tc_c = tcs[14:0];
		end
	end

	always_ff @(posedge clk) begin
		sq_s4  <= vp * vp;
		mp5_s4 <= vp * p5;
		mp2_s4 <= vp * p2;
		tc_s4  <= tc_c;
		rp_s4  <= rp_s3;
	end

	// Stage 5: square terms times P6 and P3, shifted linear terms.
	logic signed [67:0] full6, full3;
	logic [63:0]        m6_s5, m3_s5, v2a_s5, v1a_s5;
	logic signed [14:0] tc_s5;
	logic [19:0]        rp_s5;

	always_comb begin
		full6 = sq_s4 * p6;
		full3 = sq_s4 * p3;
	end

	always_ff @(posedge clk) begin
		m6_s5  <= full6[63:0];
		m3_s5  <= full3[63:0];
		v2a_s5 <= ({{22{mp5_s4[41]}}, mp5_s4} << 17) + ({{48{p4[15]}}, p4} << 35);
		v1a_s5 <= {{22{mp2_s4[41]}}, mp2_s4} << 12;
		tc_s5  <= tc_s4;
		rp_s5  <= rp_s4;
	end

	// Stage 6: sum the pressure offset terms.
	logic [63:0]        v2_s6, v1q_s6;
	logic signed [14:0] tc_s6;
	logic [19:0]        rp_s6;

	always_ff @(posedge clk) begin
		v2_s6  <= m6_s5 + v2a_s5;
		v1q_s6 <= {{8{m3_s5[63]}}, m3_s5[63:8]} + v1a_s5;
		tc_s6  <= tc_s5;
		rp_s6  <= rp_s5;
	end

	// Stage 7: divisor product and the numerator before scaling.
	logic [63:0]        xo;
	logic signed [80:0] fulld;
	logic [20:0]        pn;
	logic [63:0]        dp_s7, n0_s7;
	logic signed [14:0] tc_s7;

	always_comb begin
		xo    = v1q_s6 + 64'h0000_8000_0000_0000;
		fulld = $signed(xo) * $signed({1'b0, p1});
		pn    = 21'h10_0000 - {1'b0, rp_s6};
	end

	always_ff @(posedge clk) begin
		dp_s7 <= fulld[63:0];
		n0_s7 <= ({43'd0, pn} << 31) - v2_s6;
		tc_s7 <= tc_s6;
	end

	// Stage 8: final divisor and the scaled numerator.
	logic [30:0]        d_s8;
	logic [63:0]        n1_s8;
	logic signed [14:0] tc_s8;

	always_ff @(posedge clk) begin
		d_s8  <= dp_s7[63:33];
		n1_s8 <= n0_s7 * 64'd3125;
		tc_s8 <= tc_s7;
	end

	// Stage 9: magnitudes and signs for the divider.
	logic [63:0] num_s9;
	logic [30:0] den_s9;
	div_tag_t    tag_s9;

	always_ff @(posedge clk) begin
		num_s9     <= n1_s8[63] ? (64'd0 - n1_s8) : n1_s8;
		den_s9     <= d_s8[30] ? (31'd0 - d_s8) : d_s8;
		tag_s9.neg <= n1_s8[63] ^ d_s8[30];
		tag_s9.dz  <= (d_s8 == 31'd0);
		tag_s9.tc  <= tc_s8;
	end

	// Stages 10 to 73: the divider.
	logic [63:0] div_quo;
	div_tag_t    div_tag;

	bsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s9),
		.in_num    (num_s9),
		.in_den    (den_s9),
		.in_tag    (tag_s9),
		.out_valid (div_out_vld),
		.out_quo   (div_quo),
		.out_tag   (div_tag)
	);

	// Stage 74: restore the quotient sign.
	logic [63:0]        q_s74;
	logic               dz_s74;
	logic signed [14:0] tc_s74;

	always_ff @(posedge clk) begin
		q_s74  <= div_tag.neg ? (64'd0 - div_quo) : div_quo;
		dz_s74 <= div_tag.dz;
		tc_s74 <= div_tag.tc;
	end

	// Stage 75: partial products of the square and the P8 term.
	logic [63:0]        aq;
	logic signed [79:0] full8;
	logic [63:0]        sqlo_s75, m8_s75, q_s75;
	logic [31:0]        cross_s75;
	logic               dz_s75;
	logic signed [14:0] tc_s75;

	always_comb begin
		aq    = {{13{q_s74[63]}}, q_s74[63:13]};
		full8 = $signed(q_s74) * p8;
	end

	always_ff @(posedge clk) begin
		sqlo_s75  <= {32'd0, aq[31:0]} * {32'd0, aq[31:0]};
		cross_s75 <= aq[31:0] * aq[63:32];
		m8_s75    <= full8[63:0];
		q_s75     <= q_s74;
		dz_s75    <= dz_s74;
		tc_s75    <= tc_s74;
	end

	// Stage 76: assemble the low 64 bits of the square.
	logic [63:0]        x_s76, v2p_s76, q_s76;
	logic               dz_s76;
	logic signed [14:0] tc_s76;

	always_ff @(posedge clk) begin
		x_s76   <= sqlo_s75 + {cross_s75[30:0], 33'd0};
		v2p_s76 <= {{19{m8_s75[63]}}, m8_s75[63:19]};
		q_s76   <= q_s75;
		dz_s76  <= dz_s75;
		tc_s76  <= tc_s75;
	end

	// Stage 77: square times P9.
	logic signed [79:0] full9;
	logic [63:0]        y_s77, v2p_s77, q_s77;
	logic               dz_s77;
	logic signed [14:0] tc_s77;

	assign full9 = $signed(x_s76) * p9;

	always_ff @(posedge clk) begin
		y_s77   <= full9[63:0];
		v2p_s77 <= v2p_s76;
		q_s77   <= q_s76;
		dz_s77  <= dz_s76;
		tc_s77  <= tc_s76;
	end

	// Stage 78: sum of the pressure correction terms.
	logic [63:0]        sum_s78;
	logic               dz_s78;
	logic signed [14:0] tc_s78;

	always_ff @(posedge clk) begin
		sum_s78 <= q_s77 + {{25{y_s77[63]}}, y_s77[63:25]} + v2p_s77;
		dz_s78  <= dz_s77;
		tc_s78  <= tc_s77;
	end

	// Stage 79: final offset, saturation and the output registers.
	logic [63:0]        pf;
	logic [24:0]        press_c;
	logic [24:0]        press_s79;
	logic               dz_s79;
	logic signed [14:0] tc_s79;

	always_comb begin
		pf = {{8{sum_s78[63]}}, sum_s78[63:8]} + ({{48{p7[15]}}, p7} << 4);
		if (dz_s78 || pf[63]) begin
			press_c = '0;
		end else if (pf > {39'd0, PRESS_MAX}) begin
			press_c = PRESS_MAX;
		end else begin
			press_c = pf[24:0];
		end
	end

	always_ff @(posedge clk) begin
		press_s79 <= press_c;
		dz_s79    <= dz_s78;
		tc_s79    <= tc_s78;
	end

	assign done         = vld_s79;
	assign temp_centi   = tc_s79;
	assign press_q8     = press_s79;
	assign divisor_zero = dz_s79;

endmodule

>>> tb/tb_baro_sensor_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives raw temperature and pressure samples through the compensation
// pipeline under several trim settings. Each compensated result is compared
// with a local fixed-point predictor. Directed rows come first, then random
// samples.
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation_top
	import bsc_pkg::*;
();

	localparam int LATENCY = 79;

	// One predicted result.
	typedef struct {
		logic signed [14:0] tc;
		logic [24:0]        pq;
		logic               dz;
	} comp_t;

	// One directed stimulus row; chk_tc/chk_dz mark values typed in by hand.
	typedef struct {
		logic [19:0]        rt;
		logic [19:0]        rp;
		bit                 chk_tc;
		logic signed [14:0] tc;
		bit                 chk_dz;
		logic               dz;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [19:0]        raw_temp;
	logic [19:0]        raw_press;
	logic               done;
	logic signed [14:0] temp_centi;
	logic [24:0]        press_q8;
	logic               divisor_zero;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [63:0]        cfg_data;

	// Trim words as the predictor sees them.
	logic [47:0] trim_t;
	logic [63:0] trim_pa;
	logic [63:0] trim_pb;
	logic [15:0] trim_pc;

	comp_t       pending_results[$];
	int          errors;
	int          quiet_left;

	baro_sensor_compensation_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.raw_temp(raw_temp), .raw_press(raw_press), .done(done),
		.temp_centi(temp_centi), .press_q8(press_q8),
		.divisor_zero(divisor_zero), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Sign-extend a 16-bit trim word.
	function automatic logic signed [63:0] sx(input logic [15:0] w);
		return {{48{w[15]}}, w};
	endfunction

	// Fixed-point compensation of one sample pair with the current trims.
	function automatic comp_t compensate(input logic [19:0] rt, input logic [19:0] rp);
		logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] a, b, v1, v2, tf, t, p, d, num, q;
		logic [63:0]        mn, md, uq;
		comp_t              r;
		t1 = {48'd0, trim_t[15:0]};
		t2 = sx(trim_t[31:16]);
		t3 = sx(trim_t[47:32]);
		p1 = {48'd0, trim_pa[15:0]};
		p2 = sx(trim_pa[31:16]);
		p3 = sx(trim_pa[47:32]);
		p4 = sx(trim_pa[63:48]);
		p5 = sx(trim_pb[15:0]);
		p6 = sx(trim_pb[31:16]);
		p7 = sx(trim_pb[47:32]);
		p8 = sx(trim_pb[63:48]);
		p9 = sx(trim_pc);
		// Fine temperature and hundredths of a degree.
		a = $signed({47'd0, rt[19:3]}) - (t1 <<< 1);
		v1 = (a * t2) >>> 11;
		b = $signed({48'd0, rt[19:4]}) - t1;
		v2 = (((b * b) >>> 12) * t3) >>> 14;
		tf = v1 + v2;
		t = (tf * 5 + 128) >>> 8;
		if (t < -4000) t = -4000;
		if (t > 8500) t = 8500;
		r.tc = t[14:0];
		// Pressure terms.
		v1 = tf - 128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		d = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		r.dz = (d == 0);
		r.pq = '0;
		if (d != 0) begin
			p = 64'sd1048576 - $signed({44'd0, rp});
			num = ((p <<< 31) - v2) * 3125;
			// Truncating division on magnitudes, wrapping.
			mn = num[63] ? -num : num;
			md = d[63] ? -d : d;
			uq = mn / md;
			q = (num[63] != d[63]) ? -$signed(uq) : $signed(uq);
			a = q >>> 13;
			v1 = (p9 * a * a) >>> 25;
			v2 = (p8 * q) >>> 19;
			p = ((q + v1 + v2) >>> 8) + (p7 <<< 4);
			if (p < 0) p = 0;
			if (p > 33554431) p = 33554431;
			r.pq = p[24:0];
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				comp_t e;
				e = pending_results.pop_front();
				if (temp_centi !== e.tc) report("temp_centi", temp_centi, e.tc);
				if (press_q8 !== e.pq) report("press_q8", press_q8, e.pq);
				if (divisor_zero !== e.dz) report("divisor_zero", divisor_zero, e.dz);
			end
		end
	end

	// Random idle: about 20 in 100, except during a quiet stretch.
	function automatic bit idle_now();
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		return $urandom_range(99) < 20;
	endfunction

	// Issue one sample request, checking any typed-in values of the row.
	task automatic send_sample(input row_t rw);
		comp_t e;
		while (idle_now()) begin
			start <= 1'b0;
			@(posedge clk);
		end
		e = compensate(rw.rt, rw.rp);
		if (rw.chk_tc && e.tc !== rw.tc) report("table temp", e.tc, rw.tc);
		if (rw.chk_dz && e.dz !== rw.dz) report("table flag", e.dz, rw.dz);
		start <= 1'b1;
		raw_temp <= rw.rt;
		raw_press <= rw.rp;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(e);
	endtask

	// Wait for all results, then the pipeline depth, before a register write.
	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		while (idle_now()) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TEMP_TRIM: trim_t = val[47:0];
			REG_PRESS_A:   trim_pa = val;
			REG_PRESS_B:   trim_pb = val;
			REG_PRESS_C:   trim_pc = val[15:0];
		endcase
	endtask

	// Typical factory trims with random spread.
	task automatic load_typical();
		write_reg(REG_TEMP_TRIM, {16'hFE0C + 16'($urandom_range(200)),
			16'd26000 + 16'($urandom_range(2000)), 16'd27000 + 16'($urandom_range(2000))});
		write_reg(REG_PRESS_A, {16'd2800 + 16'($urandom_range(200)),
			16'hD0D0 + 16'($urandom_range(100)), 16'hD600 + 16'($urandom_range(100)),
			16'd36000 + 16'($urandom_range(2000))});
		write_reg(REG_PRESS_B, {16'hE000 + 16'($urandom_range(8000)),
			16'd15000 + 16'($urandom_range(300)), 16'hFFF0 + 16'($urandom_range(15)),
			16'd140 + 16'($urandom_range(10))});
		write_reg(REG_PRESS_C, 16'd6000 + 16'($urandom_range(200)));
	endtask

	initial begin
		row_t rows[$];
		row_t rw;
		errors = 0;
		quiet_left = 0;
		start = 1'b0;
		raw_temp = '0;
		raw_press = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TEMP_TRIM;
		cfg_data = '0;
		trim_t = '0;
		trim_pa = '0;
		trim_pb = '0;
		trim_pc = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every trim is zero: temperature 0, zero divisor.
		rows = '{
			'{20'h00000, 20'h00000, 1, 15'sd0, 1, 1'b1},
			'{20'hFFFFF, 20'hFFFFF, 1, 15'sd0, 1, 1'b1},
			'{20'h80000, 20'h65A00, 1, 15'sd0, 1, 1'b1}
		};
		foreach (rows[i]) send_sample(rows[i]);
		drain();

		// Typical trims: extremes of both raw fields, saturated temperatures.
		write_reg(REG_TEMP_TRIM, {16'd50, 16'd26435, 16'd27504});
		write_reg(REG_PRESS_A, {16'd2855, 16'hD0D0, 16'hD6EB, 16'd36477});
		write_reg(REG_PRESS_B, {16'd140, 16'hFFF9, 16'd15500, 16'hE000});
		write_reg(REG_PRESS_C, 16'd6000);
		rows = '{
			'{20'h00000, 20'h00000, 1, TEMP_MIN, 0, 1'b0},
			'{20'hFFFFF, 20'hFFFFF, 1, TEMP_MAX, 0, 1'b0},
			'{20'h7E000, 20'h65A00, 0, 0, 0, 1'b0},
			'{20'h80000, 20'h00001, 0, 0, 0, 1'b0},
			'{20'h84000, 20'h80000, 0, 0, 0, 1'b0},
			'{20'h55555, 20'hAAAAA, 0, 0, 0, 1'b0}
		};
		foreach (rows[i]) send_sample(rows[i]);
		drain();

		// Extreme trims: wrap-around in every intermediate.
		write_reg(REG_TEMP_TRIM, 48'hFFFF_8000_7FFF);
		write_reg(REG_PRESS_A, 64'h7FFF_8000_7FFF_FFFF);
		write_reg(REG_PRESS_B, 64'h8000_7FFF_8000_7FFF);
		write_reg(REG_PRESS_C, 16'h8000);
		rows = '{
			'{20'h00000, 20'h00000, 0, 0, 0, 1'b0},
			'{20'hFFFFF, 20'hFFFFF, 0, 0, 0, 1'b0},
			'{20'h12345, 20'hFEDCB, 0, 0, 0, 1'b0},
			'{20'hAAAAA, 20'h55555, 0, 0, 0, 1'b0}
		};
		foreach (rows[i]) send_sample(rows[i]);
		drain();
		write_reg(REG_TEMP_TRIM, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PRESS_C, 16'hFFFF);
		rows = '{
			'{20'h00000, 20'hFFFFF, 0, 0, 0, 1'b0},
			'{20'hFFFFF, 20'h00000, 0, 0, 0, 1'b0}
		};
		foreach (rows[i]) send_sample(rows[i]);
		drain();

		// Random phases: mostly realistic trims, some fully random.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph % 4 == 3) begin
				write_reg(REG_TEMP_TRIM, {$urandom, $urandom});
				write_reg(REG_PRESS_A, {$urandom, $urandom});
				write_reg(REG_PRESS_B, {$urandom, $urandom});
				write_reg(REG_PRESS_C, $urandom);
			end else begin
				load_typical();
			end
			if (ph == 5) quiet_left = 300;
			for (int n = 0; n < 95; n++) begin
				rw.rt = (n % 3 == 0) ? 20'($urandom) : 20'h70000 + 20'($urandom_range(20'h1FFFF));
				rw.rp = (n % 3 == 1) ? 20'($urandom) : 20'h50000 + 20'($urandom_range(20'h2FFFF));
				rw.chk_tc = 0;
				rw.tc = 0;
				rw.chk_dz = 0;
				rw.dz = 0;
				send_sample(rw);
			end
			drain();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
